@@ src/layer_head_rank_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the layer head rank allocator
// Each macro expects clk and rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef LAYER_HEAD_RANK_ALLOCATOR_ASSERT_SVH
`define LAYER_HEAD_RANK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication.
`define LHRA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LHRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/lhra_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lhra_pkg
// Shared constants, types and helpers of the layer head rank allocator.
// ----------------------------------------------------------------------------
package lhra_pkg;

    localparam int MAX_RANKS  = 64;
    localparam int MAX_LAYERS = 1024;
    localparam int MAX_HEADS  = 1024;

    // Field widths
    localparam int RCNT_W  = 7;   // rank count register
    localparam int RANK_W  = 6;   // rank id
    localparam int HEADS_W = 11;  // head count / share
    localparam int LAYER_W = 10;  // layer index

    // Restoring divider: one quotient bit per step
    localparam int DIV_STEPS = HEADS_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic               start;
        logic [HEADS_W-1:0] dividend;
        logic [RCNT_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [HEADS_W-1:0] quotient;
        logic [RCNT_W-1:0]  remainder;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    // Rank count clamped to 1..MAX_RANKS
    function automatic logic [RCNT_W-1:0] eff_ranks(input logic [RCNT_W-1:0] rc);
        logic [RCNT_W-1:0] r;
        r = rc;
        if (r == '0)
        begin
            r = RCNT_W'(1);
        end
        else if (r > RCNT_W'(MAX_RANKS))
        begin
            r = RCNT_W'(MAX_RANKS);
        end
        return r;
    endfunction

    // Head count clamped to MAX_HEADS
    function automatic logic [HEADS_W-1:0] sat_heads(input logic [HEADS_W-1:0] h);
        logic [HEADS_W-1:0] r;
        r = h;
        if (r > HEADS_W'(MAX_HEADS))
        begin
            r = HEADS_W'(MAX_HEADS);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ src/lhra_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lhra_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lhra_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lhra_pkg::div_req_t req,
    output lhra_pkg::div_rsp_t     rsp
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [lhra_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [lhra_pkg::HEADS_W-1:0]   quo_reg, quo_next;
    logic [lhra_pkg::RCNT_W-1:0]    rem_reg, rem_next;
    logic [lhra_pkg::RCNT_W-1:0]    dsr_reg, dsr_next;

    logic [lhra_pkg::RCNT_W:0]      trial;
    logic [lhra_pkg::RCNT_W:0]      diff;
    logic                           ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[lhra_pkg::HEADS_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        ge    = (trial >= {1'b0, dsr_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so it fits the narrow register
            quo_next  = {quo_reg[lhra_pkg::HEADS_W-2:0], ge};
            rem_next  = ge ? diff[lhra_pkg::RCNT_W-1:0] : trial[lhra_pkg::RCNT_W-1:0];
            step_next = step_reg + lhra_pkg::STEP_W'(1);
            if (step_reg == lhra_pkg::STEP_W'(lhra_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule
`default_nettype wire

@@ src/layer_head_rank_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// layer_head_rank_allocator
// Spreads the key/value heads of each layer over a configurable set of ranks.
// ----------------------------------------------------------------------------
// One input transaction carries the head count of one layer. With at least as
// many heads as ranks, one result transaction goes out per rank, rank 0 first,
// each with the quotient heads/ranks plus one for ranks below the remainder.
// With fewer heads, one result per head goes out with a share of one, on
// consecutive ranks from a round-robin offset that wraps at the rank count and
// carries over to the next layer. A layer of zero heads yields no result but
// still counts as a layer; final_layer clears the layer index and the offset
// once the layer is done. A nonzero layer is accepted, then runs through
// the shared one-bit-per-cycle divider (heads/ranks, or the old offset
// modulo ranks for a small layer), a setup step and then N results at one
// per cycle when out_stall is low, N being the rank count or the head count.
// A zero-head layer is done in the cycle it is accepted. in_stall stays
// high until the last result is loaded into the output register; the
// next layer can be accepted while that result still waits on out_stall.
// rank_count may be written only while no layer is in flight.
// ----------------------------------------------------------------------------
module layer_head_rank_allocator (
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    // configuration
    input  wire logic                          cfg_wr_en,
    input  wire logic [lhra_pkg::RCNT_W-1:0]   cfg_wr_data,

    // input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [lhra_pkg::HEADS_W-1:0]  layer_heads,
    input  wire logic                          final_layer,

    // output channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [lhra_pkg::LAYER_W-1:0]       layer_index,
    output logic [lhra_pkg::RANK_W-1:0]        rank_id,
    output logic [lhra_pkg::HEADS_W-1:0]       head_share,
    output logic                               end_of_layer
);

    lhra_pkg::state_t                state_reg, state_next;

    // configuration and cross-layer state
    logic [lhra_pkg::RCNT_W-1:0]     rank_count_reg, rank_count_next;
    logic [lhra_pkg::RANK_W-1:0]     offset_reg, offset_next;
    logic [lhra_pkg::LAYER_W-1:0]    layer_reg, layer_next;

    // per-layer job
    logic [lhra_pkg::RCNT_W-1:0]     ranks_reg, ranks_next;
    logic                            wide_reg, wide_next;
    logic                            fin_reg, fin_next;
    logic [lhra_pkg::RCNT_W-1:0]     left_reg, left_next;
    logic [lhra_pkg::RANK_W-1:0]     rank_reg, rank_next;

    // output register
    logic                            out_valid_reg, out_valid_next;
    logic [lhra_pkg::LAYER_W-1:0]    out_layer_reg, out_layer_next;
    logic [lhra_pkg::RANK_W-1:0]     out_rank_reg, out_rank_next;
    logic [lhra_pkg::HEADS_W-1:0]    out_share_reg, out_share_next;
    logic                            out_last_reg, out_last_next;

    lhra_pkg::div_req_t              div_req;
    lhra_pkg::div_rsp_t              div_rsp;

    logic                            in_take;
    logic [lhra_pkg::RCNT_W-1:0]     in_ranks;
    logic [lhra_pkg::HEADS_W-1:0]    in_heads;
    logic                            in_wide;
    logic                            out_free;
    logic [lhra_pkg::RANK_W-1:0]     rank_inc;
    logic                            rank_lt_rem;
    logic                            fin_now;
    logic                            layer_done;

    lhra_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign in_stall = (state_reg != lhra_pkg::ST_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign in_ranks = lhra_pkg::eff_ranks(rank_count_reg);
    assign in_heads = lhra_pkg::sat_heads(layer_heads);
    assign in_wide  = (in_heads >= lhra_pkg::HEADS_W'(in_ranks));
    assign out_free = !out_valid_reg || !out_stall;

    // next rank, wrapping at the rank count
    assign rank_inc = ((lhra_pkg::RCNT_W'(rank_reg) + lhra_pkg::RCNT_W'(1)) == ranks_reg)
                      ? '0 : rank_reg + lhra_pkg::RANK_W'(1);
    assign rank_lt_rem = (lhra_pkg::RCNT_W'(rank_reg) < div_rsp.remainder);

    always_comb
    begin
        state_next      = state_reg;
        rank_count_next = rank_count_reg;
        offset_next     = offset_reg;
        layer_next      = layer_reg;
        ranks_next      = ranks_reg;
        wide_next       = wide_reg;
        fin_next        = fin_reg;
        left_next       = left_reg;
        rank_next       = rank_reg;

        out_valid_next  = out_valid_reg && out_stall;
        out_layer_next  = out_layer_reg;
        out_rank_next   = out_rank_reg;
        out_share_next  = out_share_reg;
        out_last_next   = out_last_reg;

        div_req.start    = 1'b0;
        div_req.dividend = wide_next ? in_heads : lhra_pkg::HEADS_W'(offset_reg);
        div_req.divisor  = in_ranks;

        layer_done = 1'b0;
        fin_now    = fin_reg;

        if (cfg_wr_en)
        begin
            rank_count_next = cfg_wr_data;
        end

        unique case (state_reg)
            lhra_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    if (in_heads == '0)
                    begin
                        // empty layer: counts, nothing emitted, offset kept unless final_layer
                        layer_done = 1'b0;
                        fin_now    = final_layer;
                        layer_done = 1'b1;
                    end
                    else
                    begin
                        ranks_next       = in_ranks;
                        wide_next        = in_wide;
                        fin_next         = final_layer;
                        left_next        = in_wide ? in_ranks
                                                   : in_heads[lhra_pkg::RCNT_W-1:0];
                        div_req.start    = 1'b1;
                        div_req.dividend = in_wide ? in_heads
                                                   : lhra_pkg::HEADS_W'(offset_reg);
                        state_next       = lhra_pkg::ST_DIV;
                    end
                end
            end

            lhra_pkg::ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    // small layer starts at offset mod ranks
                    rank_next  = wide_reg ? '0
                                          : div_rsp.remainder[lhra_pkg::RANK_W-1:0];
                    state_next = lhra_pkg::ST_EMIT;
                end
            end

            lhra_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_layer_next = layer_reg;
                    out_rank_next  = rank_reg;
                    out_share_next = wide_reg
                                     ? div_rsp.quotient + lhra_pkg::HEADS_W'(rank_lt_rem)
                                     : lhra_pkg::HEADS_W'(1);
                    out_last_next  = (left_reg == lhra_pkg::RCNT_W'(1));
                    left_next      = left_reg - lhra_pkg::RCNT_W'(1);
                    rank_next      = rank_inc;
                    if (left_reg == lhra_pkg::RCNT_W'(1))
                    begin
                        layer_done = 1'b1;
                        if (!wide_reg)
                        begin
                            offset_next = rank_inc;
                        end
                        state_next = lhra_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = lhra_pkg::ST_IDLE;
            end
        endcase

        // layer bookkeeping once a layer is finished
        if (layer_done)
        begin
            if (fin_now)
            begin
                layer_next  = '0;
                offset_next = '0;
            end
            else if (layer_reg == lhra_pkg::LAYER_W'(lhra_pkg::MAX_LAYERS - 1))
            begin
                layer_next = '0;
            end
            else
            begin
                layer_next = layer_reg + lhra_pkg::LAYER_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lhra_pkg::ST_IDLE;
            rank_count_reg <= lhra_pkg::RCNT_W'(4);
            offset_reg     <= '0;
            layer_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rank_count_reg <= rank_count_next;
            offset_reg     <= offset_next;
            layer_reg      <= layer_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ranks_reg     <= ranks_next;
        wide_reg      <= wide_next;
        fin_reg       <= fin_next;
        left_reg      <= left_next;
        rank_reg      <= rank_next;
        out_layer_reg <= out_layer_next;
        out_rank_reg  <= out_rank_next;
        out_share_reg <= out_share_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign layer_index  = out_layer_reg;
    assign rank_id      = out_rank_reg;
    assign head_share   = out_share_reg;
    assign end_of_layer = out_last_reg;

endmodule
`default_nettype wire

@@ src/lhra_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lhra_checker
// Port-level checks of the layer head rank allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "layer_head_rank_allocator_assert.svh"

module lhra_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_stall,
    input  wire logic [lhra_pkg::HEADS_W-1:0]  layer_heads,
    input  wire logic                          out_valid,
    input  wire logic                          out_stall,
    input  wire logic [lhra_pkg::LAYER_W-1:0]  layer_index,
    input  wire logic [lhra_pkg::RANK_W-1:0]   rank_id,
    input  wire logic [lhra_pkg::HEADS_W-1:0]  head_share,
    input  wire logic                          end_of_layer
);

    logic in_xact;
    logic out_mid;

    assign in_xact = in_valid && !in_stall;
    assign out_mid = out_valid && !out_stall && !end_of_layer;

    // a stalled result holds
    `LHRA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(layer_index) && $stable(rank_id) && $stable(head_share) && $stable(end_of_layer), "result changed while stalled")

    // every result gives at least one head
    `LHRA_ASSERT_IMP(a_share_nonzero, out_valid, head_share != '0, "zero head share")

    // a nonempty layer blocks the input until its results are out
    `LHRA_ASSERT_NEXT(a_busy_after_take, in_xact && layer_heads != '0, in_stall, "input open during a layer")

    // a layer still in progress keeps the input closed
    `LHRA_ASSERT_IMP(a_busy_mid_layer, out_mid, in_stall, "input open before end of layer")

    // results of one layer share the layer index
    `LHRA_ASSERT_NEXT(a_same_layer, out_mid, !out_valid || layer_index == $past(layer_index), "layer index changed inside a layer")

endmodule

bind layer_head_rank_allocator lhra_checker u_lhra_checker (.*);
`default_nettype wire
